@@ rtl/bbc_pkg.sv @@
// shared types, bracket codes and decode functions for the bracket balance checker
package bbc_pkg;

  // 2-bit bracket kind: square, curly, round, angle
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_SQUARE = 2'd0;
  localparam kind_t KIND_CURLY  = 2'd1;
  localparam kind_t KIND_ROUND  = 2'd2;
  localparam kind_t KIND_ANGLE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_BALANCED    = 3'd0;
  localparam logic [2:0] ST_MISS_OPEN   = 3'd1;
  localparam logic [2:0] ST_WRONG_CLOSE = 3'd2;
  localparam logic [2:0] ST_MISS_CLOSE  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;

  // ascii bracket characters
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  // decoded bracket: hit flag and kind
  typedef struct packed {
    logic  hit;
    kind_t kind;
  } bracket_t;

  // command from the checker core to the stack
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_cmd_t;

  function automatic bracket_t decode_open(input logic [7:0] b);
    bracket_t r;
    r.hit  = 1'b1;
    r.kind = KIND_SQUARE;
    case (b)
      CH_OPEN_SQUARE: r.kind = KIND_SQUARE;
      CH_OPEN_CURLY:  r.kind = KIND_CURLY;
      CH_OPEN_ROUND:  r.kind = KIND_ROUND;
      CH_OPEN_ANGLE:  r.kind = KIND_ANGLE;
      default:        r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic bracket_t decode_close(input logic [7:0] b);
    bracket_t r;
    r.hit  = 1'b1;
    r.kind = KIND_SQUARE;
    case (b)
      CH_CLOSE_SQUARE: r.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  r.kind = KIND_CURLY;
      CH_CLOSE_ROUND:  r.kind = KIND_ROUND;
      CH_CLOSE_ANGLE:  r.kind = KIND_ANGLE;
      default:         r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] close_char(input kind_t k);
    logic [7:0] c;
    case (k)
      KIND_SQUARE: c = CH_CLOSE_SQUARE;
      KIND_CURLY:  c = CH_CLOSE_CURLY;
      KIND_ROUND:  c = CH_CLOSE_ROUND;
      default:     c = CH_CLOSE_ANGLE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/bracket_balance_checker.sv @@
// bracket balance checker top level: input register, check logic, result register
// words are checked from the input register; the result of a last word is written to the
//   output register when that word is checked
// throughput: one word per cycle; a last word stalls only while the output register holds a
//   result not yet taken; the stack top and the entry below it sit in registers
// reset: rst_n synchronous active low clears valids, stack count, error and position;
//   stack memory contents are not cleared
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_LINE    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [10:3] symbol, [20:11] position, [23:21] 0
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int POS_CAP_I = ((MAX_LINE - 1) < 1023) ? (MAX_LINE - 1) : 1023;
  localparam logic [9:0] POS_CAP = 10'(POS_CAP_I);

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // line state
  logic [2:0]  err_status_r, err_status_nxt;
  logic [7:0]  err_symbol_r, err_symbol_nxt;
  logic [9:0]  err_pos_r, err_pos_nxt;
  logic [9:0]  byte_pos_r, byte_pos_nxt;

  // output register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_symbol_r;
  logic [9:0]  out_pos_r;

  // stack interface
  stack_cmd_t     cmd;
  kind_t          top_kind;
  kind_t          below_kind;
  logic [CW-1:0]  stack_cnt;

  // check signals
  logic           proc;
  logic           proc_ok;
  logic           active;
  bracket_t       op;
  bracket_t       cl;
  logic           stack_full;
  logic           stack_empty;
  logic           new_err;
  logic [2:0]     new_status;
  logic [7:0]     new_symbol;
  logic [CW-1:0]  cnt_after;
  kind_t          top_after;
  logic [9:0]     len_pos;
  logic [2:0]     res_status;
  logic [7:0]     res_symbol;
  logic [9:0]     res_pos;

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .top_kind   (top_kind),
    .below_kind (below_kind),
    .count      (stack_cnt)
  );

  // handshake: a last word waits until the output register is free
  assign proc_ok   = !in_last_r || !out_valid_r || out_tready;
  assign proc      = in_valid_r && proc_ok;
  assign in_tready = !in_valid_r || proc_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // bracket decode and stack decision
  always_comb begin
    op          = decode_open(in_byte_r);
    cl          = decode_close(in_byte_r);
    active      = (err_status_r == ST_BALANCED);
    stack_full  = (stack_cnt == CW'(STACK_DEPTH));
    stack_empty = (stack_cnt == '0);

    cmd.push  = proc && active && op.hit && !stack_full;
    cmd.pop   = proc && active && cl.hit && !stack_empty && (top_kind == cl.kind);
    cmd.clear = proc && in_last_r;
    cmd.kind  = op.kind;

    new_err    = 1'b0;
    new_status = ST_BALANCED;
    new_symbol = 8'd0;
    if (active && op.hit && stack_full) begin
      new_err    = 1'b1;
      new_status = ST_OVERFLOW;
      new_symbol = in_byte_r;
    end else if (active && cl.hit && stack_empty) begin
      new_err    = 1'b1;
      new_status = ST_MISS_OPEN;
      new_symbol = in_byte_r;
    end else if (active && cl.hit && (top_kind != cl.kind)) begin
      new_err    = 1'b1;
      new_status = ST_WRONG_CLOSE;
      new_symbol = close_char(top_kind);
    end
  end

  // stack shape after this word, for the missing closer check
  always_comb begin
    cnt_after = stack_cnt;
    top_after = top_kind;
    if (cmd.push) begin
      cnt_after = stack_cnt + CW'(1);
      top_after = op.kind;
    end else if (cmd.pop) begin
      cnt_after = stack_cnt - CW'(1);
      top_after = below_kind;
    end
    len_pos = (byte_pos_r == POS_CAP) ? POS_CAP : (byte_pos_r + 10'd1);
  end

  // end of line result
  always_comb begin
    if (!active) begin
      res_status = err_status_r;
      res_symbol = err_symbol_r;
      res_pos    = err_pos_r;
    end else if (new_err) begin
      res_status = new_status;
      res_symbol = new_symbol;
      res_pos    = byte_pos_r;
    end else if (cnt_after != '0) begin
      res_status = ST_MISS_CLOSE;
      res_symbol = close_char(top_after);
      res_pos    = len_pos;
    end else begin
      res_status = ST_BALANCED;
      res_symbol = 8'd0;
      res_pos    = 10'd0;
    end
  end

  // line state update
  always_comb begin
    err_status_nxt = err_status_r;
    err_symbol_nxt = err_symbol_r;
    err_pos_nxt    = err_pos_r;
    byte_pos_nxt   = byte_pos_r;
    if (proc) begin
      if (in_last_r) begin
        err_status_nxt = ST_BALANCED;
        byte_pos_nxt   = 10'd0;
      end else begin
        if (new_err) begin
          err_status_nxt = new_status;
          err_symbol_nxt = new_symbol;
          err_pos_nxt    = byte_pos_r;
        end
        if (byte_pos_r < POS_CAP) begin
          byte_pos_nxt = byte_pos_r + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_status_r <= ST_BALANCED;
      byte_pos_r   <= 10'd0;
    end else begin
      err_status_r <= err_status_nxt;
      byte_pos_r   <= byte_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_symbol_r <= err_symbol_nxt;
    err_pos_r    <= err_pos_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      out_status_r <= res_status;
      out_symbol_r <= res_symbol;
      out_pos_r    <= res_pos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_symbol_r, out_status_r};

  // stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_cnt <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  // end of line clears the error and the position
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_last_r) |=> (err_status_r == ST_BALANCED && byte_pos_r == 10'd0))
    else $error("line state not cleared after last word");

  // a recorded error holds until the end of the line
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_status_r != ST_BALANCED && !(proc && in_last_r)) |=> $stable(err_status_r))
    else $error("recorded error changed within the line");

  // no stack movement while an error is recorded
  a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (err_status_r != ST_BALANCED) |-> (!cmd.push && !cmd.pop))
    else $error("stack moved after an error");

endmodule

@@ rtl/bbc_stack.sv @@
// bracket stack: top and next-below entries in registers, deeper entries in a memory
module bbc_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bbc_pkg::stack_cmd_t                cmd,
  output bbc_pkg::kind_t                     top_kind,
  output bbc_pkg::kind_t                     below_kind,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  kind_t          mem [STACK_DEPTH];
  kind_t          top_r;
  kind_t          below_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;

  // memory holds entries 0 .. count-2; below_r mirrors entry count-2
  assign wr_addr = AW'(count_r - CW'(1));
  assign rd_addr = AW'(count_r - CW'(3));

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // memory write of the old top on push, registered read of the entry below on pop
  always_ff @(posedge clk) begin
    if (cmd.push && (count_r != '0)) begin
      mem[wr_addr] <= top_r;
    end
    if (cmd.push) begin
      below_r <= top_r;
    end else if (cmd.pop) begin
      below_r <= mem[rd_addr];
    end
  end

  // top of stack register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= cmd.kind;
    end else if (cmd.pop) begin
      top_r <= below_r;
    end
  end

  assign top_kind   = top_r;
  assign below_kind = below_r;
  assign count      = count_r;

endmodule

@@ bench/bracket_balance_checker_tb.sv @@
// self-checking testbench for the bracket balance checker: random lines, idling, scoreboard
`timescale 1ns / 1ps

module bracket_balance_checker_tb;
  import bbc_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_LINE    = 1024;
  localparam int POS_CAP     = (MAX_LINE - 1 < 1023) ? MAX_LINE - 1 : 1023;
  localparam int RANDOM_WORDS = 650;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } line_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] symbol;
    logic [9:0] position;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] byte_value
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [2:0] status, [10:3] symbol, [20:11] position, [23:21] 0

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // words waiting to be sent, line under construction, verdicts still due
  line_word_t  pending_words[$];
  logic [7:0]  line_buf[$];
  verdict_t    verdicts_due[$];

  // predictor state for the line in progress
  kind_t       open_stack[STACK_DEPTH];
  int          open_depth = 0;
  logic [2:0]  first_err = ST_BALANCED;
  logic [7:0]  first_err_sym = 8'h00;
  logic [9:0]  first_err_pos = 10'd0;
  int          line_pos = 0;

  int          words_total = 0;
  int          words_taken = 0;
  int          lines_total = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          status_seen[5] = '{default: 0};
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] opener_of(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      KIND_ROUND:  return CH_OPEN_ROUND;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      KIND_ROUND:  return CH_CLOSE_ROUND;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  function automatic bit is_bracket(input logic [7:0] b);
    int k;
    for (k = 0; k < 4; k++)
      if (b == opener_of(kind_t'(k)) || b == closer_of(kind_t'(k))) return 1'b1;
    return 1'b0;
  endfunction

  // a byte that is not a bracket
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_bracket(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] any_bracket();
    kind_t k;
    k = kind_t'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? opener_of(k) : closer_of(k);
  endfunction

  // mostly short idle stretches, a few long ones, none while calm
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // move the line buffer to the send queue, flagging its final word
  task automatic flush_line();
    line_word_t w;
    begin
      while (line_buf.size() > 0) begin
        w.value = line_buf.pop_front();
        w.last  = (line_buf.size() == 0);
        pending_words.push_back(w);
        words_total++;
      end
      lines_total++;
    end
  endtask

  task automatic add_text(input string s);
    int i;
    begin
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      flush_line();
    end
  endtask

  // deep nesting: depth openers, then optionally all their closers
  task automatic add_deep_line(input int depth, input bit close_all);
    kind_t kinds[$];
    kind_t k;
    int i;
    begin
      for (i = 0; i < depth; i++) begin
        k = kind_t'($urandom_range(0, 3));
        kinds.push_back(k);
        line_buf.push_back(opener_of(k));
        if ($urandom_range(0, 7) == 0) line_buf.push_back(plain_byte());
      end
      if (close_all)
        while (kinds.size() > 0) line_buf.push_back(closer_of(kinds.pop_back()));
      else
        line_buf.push_back(plain_byte());
      flush_line();
    end
  endtask

  // mostly well-formed lines with random content, some bent, some pure noise
  task automatic add_random_line();
    kind_t kinds[$];
    kind_t k;
    int mode, steps, i, r;
    bit bent;
    begin
      mode  = $urandom_range(0, 9);
      steps = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      bent  = 1'b0;
      if (mode == 9) begin
        for (i = 0; i < steps; i++)
          line_buf.push_back($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
      end else begin
        for (i = 0; i < steps; i++) begin
          r = $urandom_range(0, 2);
          if (r == 0 && kinds.size() < 24) begin
            k = kind_t'($urandom_range(0, 3));
            kinds.push_back(k);
            line_buf.push_back(opener_of(k));
          end else if (r == 1 && kinds.size() > 0) begin
            k = kinds.pop_back();
            // wrong kind of closer
            if (mode == 6 && !bent && $urandom_range(0, 2) == 0) begin
              k = k + kind_t'($urandom_range(1, 3));
              bent = 1'b1;
            end
            line_buf.push_back(closer_of(k));
          end else if (r == 1 && mode == 8 && !bent) begin
            // closer with nothing open
            line_buf.push_back(closer_of(kind_t'($urandom_range(0, 3))));
            bent = 1'b1;
          end else begin
            line_buf.push_back(plain_byte());
          end
        end
        if (mode == 7) begin
          // leave the line open
          if (kinds.size() == 0) line_buf.push_back(opener_of(kind_t'($urandom_range(0, 3))));
        end else begin
          while (kinds.size() > 0) begin
            k = kinds.pop_back();
            if (mode == 6 && !bent) begin
              k = k + kind_t'($urandom_range(1, 3));
              bent = 1'b1;
            end
            line_buf.push_back(closer_of(k));
          end
        end
        if (mode == 8 && !bent) line_buf.push_back(closer_of(kind_t'($urandom_range(0, 3))));
      end
      flush_line();
    end
  endtask

  // predictor: apply one accepted word, queue the verdict at the end of a line
  task automatic track_bracket(input logic [7:0] b, input logic last);
    int ko, kc, k, len;
    int here;
    verdict_t v;
    begin
      here = line_pos;
      ko = -1;
      kc = -1;
      for (k = 0; k < 4; k++) begin
        if (b == opener_of(kind_t'(k))) ko = k;
        if (b == closer_of(kind_t'(k))) kc = k;
      end
      if (first_err == ST_BALANCED) begin
        if (ko >= 0) begin
          if (open_depth >= STACK_DEPTH) begin
            first_err = ST_OVERFLOW;
            first_err_sym = b;
            first_err_pos = 10'(here);
          end else begin
            open_stack[open_depth] = kind_t'(ko);
            open_depth++;
          end
        end else if (kc >= 0) begin
          if (open_depth == 0) begin
            first_err = ST_MISS_OPEN;
            first_err_sym = b;
            first_err_pos = 10'(here);
          end else if (open_stack[open_depth-1] == kind_t'(kc)) begin
            open_depth--;
          end else begin
            first_err = ST_WRONG_CLOSE;
            first_err_sym = closer_of(open_stack[open_depth-1]);
            first_err_pos = 10'(here);
          end
        end
      end
      if (line_pos < POS_CAP) line_pos++;

      if (last) begin
        if (first_err != ST_BALANCED) begin
          v.status = first_err;
          v.symbol = first_err_sym;
          v.position = first_err_pos;
        end else if (open_depth != 0) begin
          len = (here + 1 > POS_CAP) ? POS_CAP : here + 1;
          v.status = ST_MISS_CLOSE;
          v.symbol = closer_of(open_stack[open_depth-1]);
          v.position = 10'(len);
        end else begin
          v.status = ST_BALANCED;
          v.symbol = 8'h00;
          v.position = 10'd0;
        end
        verdicts_due.push_back(v);
        open_depth = 0;
        first_err = ST_BALANCED;
        first_err_sym = 8'h00;
        first_err_pos = 10'd0;
        line_pos = 0;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    line_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_bracket(in_tdata, in_tlast);
        words_taken++;
        if ($urandom_range(0, 149) == 0) in_calm = ~in_calm;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= w.value;
          in_tlast  <= w.last;
          in_gap = idle_len(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word %h at cycle %0d", out_tdata, cycles);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          status_seen[want.status]++;
          if (out_tdata[2:0] != want.status || out_tdata[10:3] != want.symbol ||
              out_tdata[20:11] != want.position || out_tdata[23:21] != 3'd0) begin
            if (mismatches < 10)
              $display("result mismatch at cycle %0d: status %0d/%0d symbol %h/%h pos %0d/%0d pad %b",
                       cycles, out_tdata[2:0], want.status, out_tdata[10:3], want.symbol,
                       out_tdata[20:11], want.position, out_tdata[23:21]);
            mismatches++;
          end
        end
        if ($urandom_range(0, 59) == 0) out_calm = ~out_calm;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) out_stall = idle_len(out_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int i;
    // every kind nested and balanced
    add_text("({[<a>]})");
    // closer with empty stack
    add_text("]");
    // closer of the wrong kind
    add_text("(]");
    // line ends with brackets open
    add_text("{(");
    // extreme byte values, no brackets
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    flush_line();
    // brackets after the first error are ignored
    add_text(")(((");

    // full stack that still balances, then one opener too many
    add_deep_line(STACK_DEPTH, 1'b1);
    add_deep_line(STACK_DEPTH + 1, 1'b0);
    while (words_total < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 3)
        add_deep_line($urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 6), $urandom_range(0, 1));
      else
        add_random_line();
    end
    // long line: position held at its limit and line length saturated
    line_buf.push_back(CH_OPEN_ROUND);
    for (i = 0; i < POS_CAP + 6; i++) line_buf.push_back(plain_byte());
    flush_line();
    for (i = 0; i < 4; i++) add_random_line();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken != words_total || verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) mismatches++;

    $display("%0d words in %0d lines sent, %0d cycles, %0d mismatches",
             words_taken, lines_total, cycles, mismatches);
    $display("verdicts: balanced %0d, no opener %0d, wrong closer %0d, unclosed %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
